// ===== src/led_status_pattern_generator_macros.svh =====
// assertion macros for the led status pattern generator
// expects signals named clk and arst_n in the including scope
`ifndef LED_STATUS_PATTERN_GENERATOR_MACROS_SVH
`define LED_STATUS_PATTERN_GENERATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define LSPG_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define LSPG_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/lspg_pkg.sv =====
// shared types, constants and level table function for the led pattern generator
// no dependencies
package lspg_pkg;

	localparam int BREATH_STEPS_DEF = 100;
	localparam int DUTY_BITS_DEF    = 13;

	localparam int PERIOD_BITS  = 16;
	localparam int CFG_IDX_BITS = 2;
	localparam int PAT_BITS     = 3;

	localparam logic [PERIOD_BITS-1:0] SLOW_RST   = 16'd500;
	localparam logic [PERIOD_BITS-1:0] FAST_RST   = 16'd100;
	localparam logic [PERIOD_BITS-1:0] BREATH_RST = 16'd15;

	localparam real PI_R = 3.14159265358979323846;

	typedef enum logic [PAT_BITS-1:0] {
		PAT_OFF    = 3'd0,
		PAT_ON     = 3'd1,
		PAT_SLOW   = 3'd2,
		PAT_FAST   = 3'd3,
		PAT_BREATH = 3'd4
	} pattern_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SLOW   = 2'd0,
		CFG_FAST   = 2'd1,
		CFG_BREATH = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic                mode;
		logic [PAT_BITS-1:0] led_pattern;
	} item_t;

	typedef struct packed {
		logic [PERIOD_BITS-1:0] slow_half_period;
		logic [PERIOD_BITS-1:0] fast_half_period;
		logic [PERIOD_BITS-1:0] breath_step_interval;
	} cfg_t;

	// floor(full * (1 - cos(i * step_angle)) / 2), evaluated at elaboration
	// step_angle is pi / steps
	function automatic int breath_level(int i, int steps, int bits, real step_angle);
		int  full;
		real v;
		int  fl;
		full = (1 << bits) - 1;
		if (i <= 0) return 0;
		if (i >= steps) return full;
		v  = real'(full) * (1.0 - $cos(step_angle * real'(i))) * 0.5;
		fl = int'($floor(v));
		if (fl > full) fl = full;
		if (fl < 0) fl = 0;
		return fl;
	endfunction

endpackage

// ===== src/lspg_if.sv =====
// handshake channel interfaces for pattern requests and duty results
// depends on lspg_pkg
interface lspg_item_if;
	import lspg_pkg::*;

	logic                valid;
	logic                ready;
	logic                mode;
	logic [PAT_BITS-1:0] led_pattern;

	modport source (output valid, output mode, output led_pattern, input ready);
	modport sink (input valid, input mode, input led_pattern, output ready);
endinterface

interface lspg_result_if #(
	parameter int DUTY_BITS = lspg_pkg::DUTY_BITS_DEF
);
	import lspg_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [DUTY_BITS-1:0] duty_out;
	logic [PAT_BITS-1:0]  active_pattern;

	modport source (output valid, output duty_out, output active_pattern, input ready);
	modport sink (input valid, input duty_out, input active_pattern, output ready);
endinterface

// ===== src/led_status_pattern_generator.sv =====
// top level of the status led pattern generator: channels, config registers, stages
// depends on lspg_pkg, lspg_if, lspg_engine and the assertion macro header
//
// usage:
// - item channel: mode 0 is a 1 ms tick, mode 1 a pattern request (led_pattern
//   0 off, 1 on, 2 slow blink, 3 fast blink, 4 breathing); every transfer yields
//   exactly one result on the result channel, in order
// - result channel: duty_out is the pwm duty now driven, active_pattern the
//   pattern in force
// - config port: cfg_we with cfg_idx 0 slow half period, 1 fast half period,
//   2 breathing step interval, all in ticks; write only while the block is idle
// - timing: an item enters the input stage at its transfer, then the result register
//   when that is free or being emptied; one item per cycle sustained while results
//   are taken, set by the single register stage that holds the pattern state
// - breathing levels come from a constant table read once per item
// - reset: pattern off, duty 0, counters clear, registers 500/100/15
// - receiver stall: the result register holds, one item waits in the input
//   stage, then item ready drops until the result is taken
`include "led_status_pattern_generator_macros.svh"

module led_status_pattern_generator #(
	parameter int BREATH_STEPS = lspg_pkg::BREATH_STEPS_DEF,
	parameter int DUTY_BITS    = lspg_pkg::DUTY_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lspg_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [lspg_pkg::PERIOD_BITS-1:0]   cfg_data,
	lspg_item_if.sink                          item,
	lspg_result_if.source                      result
);
	import lspg_pkg::*;

	cfg_t                 cfg_q;
	item_t                item_s1, step;
	logic                 valid_s1, adv, out_valid_q;
	logic [DUTY_BITS-1:0] duty_next, duty_q;
	logic [PAT_BITS-1:0]  pattern_next, pattern_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slow_half_period     <= SLOW_RST;
			cfg_q.fast_half_period     <= FAST_RST;
			cfg_q.breath_step_interval <= BREATH_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_SLOW:   cfg_q.slow_half_period     <= cfg_data;
				CFG_FAST:   cfg_q.fast_half_period     <= cfg_data;
				CFG_BREATH: cfg_q.breath_step_interval <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage advances when the result register is free or being emptied
	assign adv        = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.mode        <= item.mode;
			item_s1.led_pattern <= item.led_pattern;
		end
	end

	assign step = item_s1;

	lspg_engine #(
		.BREATH_STEPS (BREATH_STEPS),
		.DUTY_BITS    (DUTY_BITS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (adv),
		.step         (step),
		.cfg          (cfg_q),
		.duty_next    (duty_next),
		.pattern_next (pattern_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			duty_q    <= duty_next;
			pattern_q <= pattern_next;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.duty_out       = duty_q;
	assign result.active_pattern = pattern_q;

	`LSPG_ASSERT_NOW(a_off_dark, result.valid && (result.active_pattern == PAT_OFF), result.duty_out == '0, "off pattern with nonzero duty")
	`LSPG_ASSERT_NOW(a_on_full, result.valid && (result.active_pattern == PAT_ON), result.duty_out == '1, "on pattern without full duty")
	`LSPG_ASSERT_NOW(a_blink_rail, result.valid && ((result.active_pattern == PAT_SLOW) || (result.active_pattern == PAT_FAST)), (result.duty_out == '0) || (result.duty_out == '1), "blink duty not at a rail")
	`LSPG_ASSERT_NEXT(a_stage_hold, valid_s1 && result.valid && !result.ready, valid_s1, "input stage lost an item during a stall")

endmodule

// ===== src/lspg_engine.sv =====
// pattern state, tick counting and breathing level lookup
// depends on lspg_pkg
module lspg_engine #(
	parameter int BREATH_STEPS = lspg_pkg::BREATH_STEPS_DEF,
	parameter int DUTY_BITS    = lspg_pkg::DUTY_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step_en,
	input  lspg_pkg::item_t                step,
	input  lspg_pkg::cfg_t                 cfg,
	output logic [DUTY_BITS-1:0]           duty_next,
	output logic [lspg_pkg::PAT_BITS-1:0]  pattern_next
);
	import lspg_pkg::*;

	localparam int IDX_BITS = $clog2(BREATH_STEPS + 1);
	localparam logic [IDX_BITS-1:0]  LAST_IDX = IDX_BITS'(BREATH_STEPS);
	localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;
	localparam real STEP_ANGLE = PI_R / real'(BREATH_STEPS);

	logic [DUTY_BITS-1:0] level_tab [BREATH_STEPS+1];

	for (genvar g = 0; g <= BREATH_STEPS; g++) begin : g_level
		assign level_tab[g] = DUTY_BITS'(breath_level(g, BREATH_STEPS, DUTY_BITS, STEP_ANGLE));
	end

	pattern_t               pattern_q, pattern_d;
	logic [DUTY_BITS-1:0]   duty_q, duty_d, toggle_duty, breath_duty;
	logic [PERIOD_BITS-1:0] tick_q, tick_d, tick_inc, period;
	logic [IDX_BITS-1:0]    idx_q, idx_d, tab_sel;
	logic                   fall_q, fall_d;
	logic                   expired, load_breath, req_ok;

	assign tick_inc    = tick_q + PERIOD_BITS'(1);
	assign expired     = (tick_inc >= period);
	assign toggle_duty = (duty_q == '0) ? DUTY_MAX : '0;
	assign req_ok      = (step.led_pattern <= PAT_BREATH) && (step.led_pattern != pattern_q);

	always_comb begin
		unique case (pattern_q)
			PAT_SLOW: period = cfg.slow_half_period;
			PAT_FAST: period = cfg.fast_half_period;
			default:  period = cfg.breath_step_interval;
		endcase
	end

	always_comb begin
		pattern_d   = pattern_q;
		duty_d      = duty_q;
		tick_d      = tick_q;
		idx_d       = idx_q;
		fall_d      = fall_q;
		load_breath = 1'b0;
		if (step.mode) begin
			if (req_ok) begin
				pattern_d = pattern_t'(step.led_pattern);
				tick_d    = '0;
				idx_d     = '0;
				fall_d    = 1'b0;
				unique case (pattern_t'(step.led_pattern))
					PAT_OFF:    duty_d = '0;
					PAT_ON:     duty_d = DUTY_MAX;
					PAT_BREATH: load_breath = 1'b1;
					default:    duty_d = toggle_duty;
				endcase
			end
		end else begin
			unique case (pattern_q)
				PAT_SLOW, PAT_FAST: begin
					tick_d = expired ? '0 : tick_inc;
					if (expired) duty_d = toggle_duty;
				end
				PAT_BREATH: begin
					tick_d = expired ? '0 : tick_inc;
					if (expired) begin
						load_breath = 1'b1;
						if (idx_q < LAST_IDX) begin
							idx_d = idx_q + IDX_BITS'(1);
						end else begin
							idx_d  = '0;
							fall_d = ~fall_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign tab_sel      = fall_d ? (LAST_IDX - idx_d) : idx_d;
	assign breath_duty  = level_tab[tab_sel];
	assign duty_next    = load_breath ? breath_duty : duty_d;
	assign pattern_next = pattern_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= PAT_OFF;
			duty_q    <= '0;
			tick_q    <= '0;
			idx_q     <= '0;
			fall_q    <= 1'b0;
		end else if (step_en) begin
			pattern_q <= pattern_d;
			duty_q    <= duty_next;
			tick_q    <= tick_d;
			idx_q     <= idx_d;
			fall_q    <= fall_d;
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// testbench for the status led pattern generator: directed and random ticks and requests
// checks every duty result against a bit-exact blink and breathing predictor
// depends on lspg_pkg, lspg_if and led_status_pattern_generator
module tb_top;
	import lspg_pkg::*;

	localparam int STEPS = BREATH_STEPS_DEF;
	localparam int DBITS = DUTY_BITS_DEF;
	localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
	localparam int PAT_CODES = 1 << PAT_BITS;
	localparam logic TICK = 1'b0;
	localparam logic REQUEST = 1'b1;
	localparam int HOLD_CYCLES = 60;
	localparam int STALL_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 6;
	localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
	localparam logic [63:0] FULL64 = 64'((1 << DBITS) - 1);

	typedef logic [DBITS-1:0] duty_t;
	typedef struct {
		duty_t    duty;
		pattern_t pattern;
	} result_due_t;

	class duty_scoreboard;
		logic [PERIOD_BITS-1:0] slow_half;
		logic [PERIOD_BITS-1:0] fast_half;
		logic [PERIOD_BITS-1:0] step_interval;
		pattern_t               pattern;
		duty_t                  duty;
		logic [PERIOD_BITS-1:0] ticks;
		int                     step;
		bit                     falling;
		duty_t                  levels[STEPS+1];
		result_due_t            duty_due[$];
		int                     errors;
		int                     items_noted;
		int                     results_seen;

		function new();
			slow_half = SLOW_RST;
			fast_half = FAST_RST;
			step_interval = BREATH_RST;
			pattern = PAT_OFF;
			duty = '0;
			ticks = '0;
			step = 0;
			falling = 1'b0;
			errors = 0;
			items_noted = 0;
			results_seen = 0;
			for (int i = 0; i <= STEPS; i++)
				levels[i] = level_of(i);
		endfunction

		function logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
			logic [127:0] p;
			p = {64'd0, a} * {64'd0, b};
			return p[125:62];
		endfunction

		// taylor series, 0 <= x <= pi/2
		function logic [63:0] q62_sin(logic [63:0] x);
			logic [63:0] x2;
			logic [63:0] term;
			logic [63:0] sum;
			logic [63:0] div;
			x2 = q62_mul(x, x);
			term = x;
			sum = x;
			for (int k = 1; k <= 13; k++) begin
				div = 64'((2 * k) * (2 * k + 1));
				term = q62_mul(term, x2) / div;
				if (k % 2 == 1)
					sum = sum - term;
				else
					sum = sum + term;
			end
			return sum;
		endfunction

		// floor(full * sin^2(pi*i/(2*steps)))
		function duty_t level_of(int i);
			logic [63:0]  two_n;
			logic [63:0]  ii;
			logic [63:0]  x;
			logic [63:0]  s2;
			logic [63:0]  v;
			logic [127:0] p;
			if (i == 0)
				return '0;
			if (i >= STEPS)
				return FULL64[DBITS-1:0];
			two_n = 64'(2 * STEPS);
			ii = 64'(i);
			x = (PI_Q62 / two_n) * ii + ((PI_Q62 % two_n) * ii) / two_n;
			s2 = q62_mul(q62_sin(x), q62_sin(x));
			p = {64'd0, FULL64} * {64'd0, s2};
			v = p[125:62];
			if (v > FULL64)
				v = FULL64;
			return v[DBITS-1:0];
		endfunction

		function duty_t breath_duty();
			int idx;
			idx = (step > STEPS) ? STEPS : step;
			return falling ? levels[STEPS - idx] : levels[idx];
		endfunction

		function duty_t toggled(duty_t d);
			return (d == '0) ? FULL64[DBITS-1:0] : '0;
		endfunction

		function bit period_done(logic [PERIOD_BITS-1:0] period);
			ticks = ticks + 1'b1;
			if (ticks >= period) begin
				ticks = '0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void set_register(logic [CFG_IDX_BITS-1:0] idx, logic [PERIOD_BITS-1:0] v);
			case (idx)
				CFG_SLOW: slow_half = v;
				CFG_FAST: fast_half = v;
				CFG_BREATH: step_interval = v;
				default: ;
			endcase
		endfunction

		function void note_item(logic m, logic [PAT_BITS-1:0] req);
			result_due_t e;
			items_noted++;
			if (m == REQUEST) begin
				if (req <= PAT_BREATH && req != pattern) begin
					pattern = pattern_t'(req);
					ticks = '0;
					step = 0;
					falling = 1'b0;
					case (pattern)
						PAT_OFF: duty = '0;
						PAT_ON: duty = FULL64[DBITS-1:0];
						PAT_BREATH: duty = breath_duty();
						default: duty = toggled(duty);
					endcase
				end
			end else begin
				case (pattern)
					PAT_SLOW: if (period_done(slow_half)) duty = toggled(duty);
					PAT_FAST: if (period_done(fast_half)) duty = toggled(duty);
					PAT_BREATH: if (period_done(step_interval)) begin
						if (step < STEPS) begin
							step++;
						end else begin
							step = 0;
							falling = !falling;
						end
						duty = breath_duty();
					end
					default: ;
				endcase
			end
			e.duty = duty;
			e.pattern = pattern;
			duty_due.push_back(e);
		endfunction

		task report(string msg);
			errors++;
			$display("tb_top: mismatch: %s", msg);
		endtask

		task check_result(duty_t d, logic [PAT_BITS-1:0] p);
			result_due_t e;
			results_seen++;
			if (duty_due.size() == 0) begin
				report($sformatf("result %0d with nothing expected: duty %0d pattern %0d",
					results_seen, d, p));
				return;
			end
			e = duty_due.pop_front();
			if (d !== e.duty)
				report($sformatf("result %0d duty_out %0d, expected %0d",
					results_seen, d, e.duty));
			if (p !== e.pattern)
				report($sformatf("result %0d active_pattern %0d, expected %0d",
					results_seen, p, e.pattern));
		endtask
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_idx;
	logic [PERIOD_BITS-1:0]  cfg_data;
	bit                      calm = 1'b0;
	int                      hold_asked = 0;
	int                      idle_cycles = 0;
	duty_scoreboard          sb;

	lspg_item_if item_ch();
	lspg_result_if #(.DUTY_BITS(DBITS)) res_ch();

	led_status_pattern_generator #(
		.BREATH_STEPS(STEPS),
		.DUTY_BITS(DBITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.item(item_ch),
		.result(res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_item(input logic m, input logic [PAT_BITS-1:0] p);
		if (!calm && $urandom_range(0, 4) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.mode <= m;
		item_ch.led_pattern <= p;
		do @(negedge clk); while (item_ch.ready !== 1'b1);
		@(posedge clk);
		sb.note_item(m, p);
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (sb.duty_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [PERIOD_BITS-1:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.set_register(idx, v);
	endtask

	task automatic program_registers(input logic [PERIOD_BITS-1:0] s,
		input logic [PERIOD_BITS-1:0] f, input logic [PERIOD_BITS-1:0] b);
		drain();
		write_reg(CFG_SLOW, s);
		write_reg(CFG_FAST, f);
		write_reg(CFG_BREATH, b);
		write_reg(CFG_UNUSED, PERIOD_BITS'($urandom));
		cfg_we <= 1'b0;
	endtask

	task automatic random_items(input int n, input int req_pct, input bit breath_only);
		logic [PAT_BITS-1:0] p;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < req_pct) begin
				if ($urandom_range(0, 9) == 0)
					p = PAT_BITS'($urandom_range(PAT_BREATH + 1, PAT_CODES - 1));
				else if (breath_only)
					p = PAT_BREATH;
				else
					p = PAT_BITS'($urandom_range(PAT_OFF, PAT_BREATH));
				send_item(REQUEST, p);
			end else begin
				send_item(TICK, PAT_BITS'($urandom));
			end
		end
	endtask

	initial begin : stimulus
		sb = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= '0;
		cfg_data <= '0;
		item_ch.valid <= 1'b0;
		item_ch.mode <= 1'b0;
		item_ch.led_pattern <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: repeated, unknown and every pattern request
		send_item(TICK, PAT_OFF);
		send_item(REQUEST, PAT_OFF);
		send_item(REQUEST, PAT_ON);
		send_item(TICK, PAT_BITS'(PAT_CODES - 1));
		send_item(REQUEST, PAT_ON);
		for (int c = PAT_BREATH + 1; c < PAT_CODES; c++)
			send_item(REQUEST, PAT_BITS'(c));
		send_item(REQUEST, PAT_SLOW);
		send_item(TICK, PAT_OFF);
		send_item(REQUEST, PAT_FAST);
		send_item(REQUEST, PAT_BREATH);
		send_item(TICK, PAT_ON);
		send_item(REQUEST, PAT_OFF);

		// zero and one periods
		program_registers(16'd1, 16'd0, 16'd1);
		send_item(REQUEST, PAT_FAST);
		send_item(TICK, PAT_OFF);
		send_item(TICK, PAT_BITS'(PAT_CODES - 1));
		send_item(REQUEST, PAT_SLOW);
		send_item(TICK, PAT_OFF);
		send_item(TICK, PAT_OFF);
		send_item(REQUEST, PAT_BREATH);
		repeat (3) send_item(TICK, PAT_OFF);
		send_item(REQUEST, PAT_ON);

		// short periods, with a long receiver hold-off
		program_registers(PERIOD_BITS'($urandom_range(1, 8)), PERIOD_BITS'($urandom_range(1, 4)),
			PERIOD_BITS'($urandom_range(1, 3)));
		hold_asked++;
		random_items(220, 6, 1'b0);

		// longest periods, counts grow
		program_registers(16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_items(80, 5, 1'b0);

		// lowered periods fire on the next tick
		program_registers(PERIOD_BITS'($urandom_range(1, 30)), PERIOD_BITS'($urandom_range(1, 10)),
			PERIOD_BITS'($urandom_range(1, 4)));
		random_items(200, 4, 1'b0);

		// full breathing cycles, no idling
		program_registers(16'd2, 16'd1, 16'd1);
		calm = 1'b1;
		send_item(REQUEST, PAT_OFF);
		send_item(REQUEST, PAT_BREATH);
		random_items(420, 2, 1'b1);

		drain();
		$display("tb_top: %0d items sent, %0d results checked, %0d mismatches",
			sb.items_noted, sb.results_seen, sb.errors);
		$display("tb_top: covered blink toggles, breathing rise and fall, periods 0 to 65535");
		if (sb.errors == 0 && sb.duty_due.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

	initial begin : receiver
		int stall_left;
		int hold_taken;
		stall_left = 0;
		hold_taken = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_taken != hold_asked) begin
				hold_taken = hold_asked;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 5);
			end
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// values seen at the falling edge are the ones the next rising edge transfers
	always @(negedge clk) begin
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
			sb.check_result(res_ch.duty_out, res_ch.active_pattern);
	end

	always @(negedge clk) begin
		if (arst_n !== 1'b1 || (item_ch.valid === 1'b1 && item_ch.ready === 1'b1)
			|| (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb_top: no transfer for %0d cycles", STALL_LIMIT);
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/lspg_pkg.sv
src/lspg_if.sv
src/lspg_engine.sv
src/led_status_pattern_generator.sv
dv/tb_top.sv
